>>> design/usbsrr_pkg.sv
// Shared types and constants for the USB standard request responder.
package usbsrr_pkg;

    typedef enum logic [1:0] {
        ACT_STALL = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_RESET = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_SELF_POWERED    = 3'd0,
        CFG_CONFIG_DESC_LEN = 3'd1,
        CFG_VENDOR_STR_LEN  = 3'd2,
        CFG_PRODUCT_STR_LEN = 3'd3,
        CFG_SERIAL_STR_LEN  = 3'd4,
        CFG_HID_PRESENT     = 3'd5,
        CFG_IN_EP_NUMBER    = 3'd6,
        CFG_OUT_EP_NUMBER   = 3'd7
    } cfg_reg_t;

    // bRequest codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;

    // bmRequestType values
    localparam logic [7:0] RT_OUT_DEVICE   = 8'h00;
    localparam logic [7:0] RT_OUT_ENDPOINT = 8'h02;
    localparam logic [7:0] RT_IN_DEVICE    = 8'h80;
    localparam logic [7:0] RT_IN_INTERFACE = 8'h81;
    localparam logic [7:0] RT_IN_ENDPOINT  = 8'h82;

    // descriptor types
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_HID    = 8'h21;

    localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;
    localparam logic [15:0] FEAT_EP_HALT       = 16'd0;

    localparam logic [6:0]  SETUP_BYTES     = 7'd8;
    localparam logic [15:0] LEN_DEVICE_DESC = 16'd18;
    localparam logic [15:0] LEN_LANG_STR    = 16'd4;
    localparam logic [15:0] LEN_HID_DESC    = 16'd9;
    localparam logic [15:0] LEN_STATUS      = 16'd2;
    localparam logic [15:0] LEN_ONE_BYTE    = 16'd1;

    localparam int EP0_PACKET_SIZE = 32;
    localparam int ZLP_BITS        = $clog2(EP0_PACKET_SIZE);

endpackage

>>> design/usb_standard_request_responder.sv
// Top level: USB standard request responder with device state and config registers.
// Usage:
//   s_* channel: one item per valid/ready handshake, either a decoded SETUP packet
//   (s_op = 0) or a bus reset event (s_op = 1).
//   m_* channel: exactly one result per input item, in order: action (stall, data
//   in, status ack, reset done), first reply byte, clipped data-in length, ZLP
//   flag, and the device address / address-enabled state after the item.
//   cfg_* channel: register writes, always ready; write only while idle.
// Timing: an accepted item is registered in the input register, then decoded into
//   the result register, where it shows as valid. Throughput: one item per cycle
//   while m_ready is high, set by the single decode pass between the two registers;
//   state updates as an item moves to the result register.
// Reset (aresetn low, synchronous): config registers take their defaults,
//   configuration 0, no address, only endpoint 0 enabled, nothing halted, both
//   stages empty.
// Stall: while m_ready is low a result holds; one more item can sit in the input
//   register, after which s_ready drops.
module usb_standard_request_responder
    import usbsrr_pkg::*;
#(
    parameter int NUM_ENDPOINTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [6:0]  s_setup_byte_count,
    input  logic [7:0]  s_request_type,
    input  logic [7:0]  s_request_code,
    input  logic [15:0] s_request_value,
    input  logic [15:0] s_request_index,
    input  logic [15:0] s_request_length,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_reply_byte,
    output logic [15:0] m_transfer_length,
    output logic        m_send_zlp,
    output logic [6:0]  m_device_address,
    output logic        m_address_enabled
);

    localparam int EP_IDX_W = $clog2(NUM_ENDPOINTS + 1);
    localparam logic [3:0] EP_NUM_MAX = 4'(NUM_ENDPOINTS);
    localparam logic [NUM_ENDPOINTS:0] EP_EN_RESET = {{NUM_ENDPOINTS{1'b0}}, 1'b1};

    // config registers
    logic        self_pw_reg;
    logic [9:0]  cfg_desc_len_reg;
    logic [7:0]  vendor_len_reg;
    logic [7:0]  product_len_reg;
    logic [7:0]  serial_len_reg;
    logic        hid_reg;
    logic [2:0]  in_ep_reg;
    logic [2:0]  out_ep_reg;

    // device state
    logic [7:0]             conf_idx_reg, conf_idx_next;
    logic                   rwu_reg, rwu_next;
    logic [6:0]             addr_reg, addr_next;
    logic                   addr_vld_reg, addr_vld_next;
    logic [NUM_ENDPOINTS:0] ep_en_reg, ep_en_next;
    logic [NUM_ENDPOINTS:0] ep_halt_reg, ep_halt_next;

    // input stage
    logic        in_vld_reg;
    logic        op_reg;
    logic [6:0]  cnt_reg;
    logic [7:0]  rtype_reg;
    logic [7:0]  code_reg;
    logic [15:0] wval_reg;
    logic [15:0] widx_reg;
    logic [15:0] wlen_reg;

    // result stage
    logic        out_vld_reg;
    action_t     act_reg;
    logic [7:0]  reply_reg;
    logic [15:0] len_reg;
    logic        zlp_reg;
    logic [6:0]  addr_out_reg;
    logic        addr_vld_out_reg;

    // decode
    logic                advance;
    action_t             act;
    logic [7:0]          reply;
    logic [15:0]         len;
    logic [15:0]         len_clip;
    logic                zlp;
    logic [7:0]          dtype;
    logic [7:0]          dindex;
    logic [3:0]          ep_num;
    logic [EP_IDX_W-1:0] ep_sel;
    logic                ep_ok;
    logic [15:0]         str_len;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;

    assign dtype  = wval_reg[15:8];
    assign dindex = wval_reg[7:0];
    assign ep_num = widx_reg[3:0];
    assign ep_sel = ep_num[EP_IDX_W-1:0];
    assign ep_ok  = (ep_num <= EP_NUM_MAX) && ep_en_reg[ep_sel];

    always_comb begin
        case (dindex)
            8'd0:    str_len = LEN_LANG_STR;
            8'd1:    str_len = {8'd0, vendor_len_reg};
            8'd2:    str_len = {8'd0, product_len_reg};
            8'd3:    str_len = {8'd0, serial_len_reg};
            default: str_len = 16'd0;
        endcase
    end

    always_comb begin
        act           = ACT_STALL;
        reply         = 8'd0;
        len           = 16'd0;
        conf_idx_next = conf_idx_reg;
        rwu_next      = rwu_reg;
        addr_next     = addr_reg;
        addr_vld_next = addr_vld_reg;
        ep_en_next    = ep_en_reg;
        ep_halt_next  = ep_halt_reg;
        if (op_reg) begin
            conf_idx_next = 8'd0;
            rwu_next      = 1'b0;
            addr_next     = 7'd0;
            addr_vld_next = 1'b0;
            ep_en_next    = EP_EN_RESET;
            ep_halt_next  = '0;
            act           = ACT_RESET;
        end else if (cnt_reg != SETUP_BYTES || rtype_reg[6:5] != 2'b00) begin
            act = ACT_STALL;
        end else begin
            case (code_reg)
                REQ_GET_STATUS: begin
                    if (rtype_reg == RT_IN_DEVICE) begin
                        reply = {6'd0, rwu_reg, self_pw_reg};
                        len   = LEN_STATUS;
                        act   = ACT_DATA;
                    end else if (rtype_reg == RT_IN_INTERFACE && widx_reg == 16'd0) begin
                        len = LEN_STATUS;
                        act = ACT_DATA;
                    end else if (rtype_reg == RT_IN_ENDPOINT && ep_ok) begin
                        reply = {7'd0, ep_halt_reg[ep_sel]};
                        len   = LEN_STATUS;
                        act   = ACT_DATA;
                    end
                end
                REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                    if (rtype_reg == RT_OUT_DEVICE && wval_reg == FEAT_REMOTE_WAKEUP) begin
                        rwu_next = (code_reg == REQ_SET_FEATURE);
                        act      = ACT_ACK;
                    end else if (rtype_reg == RT_OUT_ENDPOINT && wval_reg == FEAT_EP_HALT) begin
                        if (ep_ok) begin
                            ep_halt_next[ep_sel] = (code_reg == REQ_SET_FEATURE);
                            act                  = ACT_ACK;
                        end
                    end
                end
                REQ_SET_ADDRESS: begin
                    if (rtype_reg == RT_OUT_DEVICE) begin
                        addr_next     = wval_reg[6:0];
                        addr_vld_next = 1'b1;
                        act           = ACT_ACK;
                    end
                end
                REQ_GET_DESCRIPTOR: begin
                    if (rtype_reg == RT_IN_DEVICE) begin
                        if (dtype == DT_DEVICE && dindex == 8'd0) begin
                            len = LEN_DEVICE_DESC;
                            act = ACT_DATA;
                        end else if (dtype == DT_CONFIG && dindex == 8'd0) begin
                            len = {6'd0, cfg_desc_len_reg};
                            act = ACT_DATA;
                        end else if (dtype == DT_STRING && str_len != 16'd0) begin
                            len = str_len;
                            act = ACT_DATA;
                        end
                    end else if (rtype_reg == RT_IN_INTERFACE && hid_reg && dtype == DT_HID) begin
                        len = LEN_HID_DESC;
                        act = ACT_DATA;
                    end
                end
                REQ_GET_CONFIGURATION: begin
                    if (rtype_reg == RT_IN_DEVICE) begin
                        reply = conf_idx_reg;
                        len   = LEN_ONE_BYTE;
                        act   = ACT_DATA;
                    end
                end
                REQ_SET_CONFIGURATION: begin
                    if (rtype_reg == RT_OUT_DEVICE) begin
                        conf_idx_next = dindex;
                        for (int i = 1; i <= NUM_ENDPOINTS; i++) begin
                            ep_en_next[i]   = (dindex != 8'd0) &&
                                              ({1'b0, in_ep_reg} == 4'(i) ||
                                               {1'b0, out_ep_reg} == 4'(i));
                            ep_halt_next[i] = 1'b0;
                        end
                        act = ACT_ACK;
                    end
                end
                REQ_GET_INTERFACE: begin
                    if (rtype_reg == RT_IN_INTERFACE) begin
                        len = LEN_ONE_BYTE;
                        act = ACT_DATA;
                    end
                end
                default: act = ACT_STALL;
            endcase
        end
        len_clip = (len > wlen_reg) ? wlen_reg : len;
        zlp      = (act == ACT_DATA) && (len_clip[ZLP_BITS-1:0] == '0);
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_pw_reg      <= 1'b1;
            cfg_desc_len_reg <= 10'd34;
            vendor_len_reg   <= 8'd0;
            product_len_reg  <= 8'd0;
            serial_len_reg   <= 8'd0;
            hid_reg          <= 1'b0;
            in_ep_reg        <= 3'd3;
            out_ep_reg       <= 3'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SELF_POWERED:    self_pw_reg      <= cfg_data[0];
                CFG_CONFIG_DESC_LEN: cfg_desc_len_reg <= cfg_data;
                CFG_VENDOR_STR_LEN:  vendor_len_reg   <= cfg_data[7:0];
                CFG_PRODUCT_STR_LEN: product_len_reg  <= cfg_data[7:0];
                CFG_SERIAL_STR_LEN:  serial_len_reg   <= cfg_data[7:0];
                CFG_HID_PRESENT:     hid_reg          <= cfg_data[0];
                CFG_IN_EP_NUMBER:    in_ep_reg        <= cfg_data[2:0];
                CFG_OUT_EP_NUMBER:   out_ep_reg       <= cfg_data[2:0];
                default:             hid_reg          <= hid_reg;
            endcase
        end
    end

    // device state and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            conf_idx_reg <= 8'd0;
            rwu_reg      <= 1'b0;
            addr_reg     <= 7'd0;
            addr_vld_reg <= 1'b0;
            ep_en_reg    <= EP_EN_RESET;
            ep_halt_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg  <= 1'b1;
                conf_idx_reg <= conf_idx_next;
                rwu_reg      <= rwu_next;
                addr_reg     <= addr_next;
                addr_vld_reg <= addr_vld_next;
                ep_en_reg    <= ep_en_next;
                ep_halt_reg  <= ep_halt_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            cnt_reg   <= s_setup_byte_count;
            rtype_reg <= s_request_type;
            code_reg  <= s_request_code;
            wval_reg  <= s_request_value;
            widx_reg  <= s_request_index;
            wlen_reg  <= s_request_length;
        end
        if (advance) begin
            act_reg          <= act;
            reply_reg        <= (act == ACT_DATA) ? reply : 8'd0;
            len_reg          <= (act == ACT_DATA) ? len_clip : 16'd0;
            zlp_reg          <= zlp;
            addr_out_reg     <= addr_next;
            addr_vld_out_reg <= addr_vld_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_action          = act_reg;
    assign m_reply_byte      = reply_reg;
    assign m_transfer_length = len_reg;
    assign m_send_zlp        = zlp_reg;
    assign m_device_address  = addr_out_reg;
    assign m_address_enabled = addr_vld_out_reg;

`ifndef ASSERT_OFF
    a_ep0_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        ep_en_reg[0])
        else $error("endpoint 0 not enabled");

    a_halt_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (ep_halt_reg & ~ep_en_reg) == '0)
        else $error("halted endpoint is not enabled");

    a_reset_clears_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ACT_RESET |-> !m_address_enabled && m_device_address == 7'd0)
        else $error("bus reset result carries an address");

    a_no_data_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != ACT_DATA |->
            m_transfer_length == 16'd0 && !m_send_zlp && m_reply_byte == 8'd0)
        else $error("non data result carries data fields");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(addr_reg) && $stable(ep_en_reg))
        else $error("state changed while result stalled");
`endif

endmodule
